### rtl/core/cbfr_pkg.sv
// Shared types, constants and helpers for the chunked bit field reader.
// No dependencies; every other file of the block imports this package.
package cbfr_pkg;

    localparam int MAX_CHUNK_BYTES = 4;
    localparam int WORD_W          = MAX_CHUNK_BYTES * 8;
    localparam int SIZE_W          = 3;
    localparam int CNT_W           = 6;
    localparam int STAT_W          = 2;
    localparam int MAX_FIELD_BITS  = 32;
    localparam int S_TDATA_W       = 40;
    localparam int S_TUSER_W       = 1;
    localparam int M_TDATA_W       = WORD_W;
    localparam int M_TUSER_W       = STAT_W;
    localparam int CMD_DEPTH       = 2;
    localparam int CMD_PTR_W       = 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK,
        STAT_NO_DATA,
        STAT_QUEUE_FULL,
        STAT_BAD_COUNT
    } status_t;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_READ,
        KIND_EMPTY,
        KIND_BAD
    } kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RUN,
        BK_LOAD,
        BK_DRAIN,
        BK_FIX
    } back_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [WORD_W-1:0]  word;
        logic [SIZE_W-1:0]  bytes;
        logic [CNT_W-1:0]   count;
        logic               low_end;
        logic               first_low;
    } cmd_t;

    function automatic logic [WORD_W-1:0] byte_mask(input logic [SIZE_W-1:0] nbytes);
        logic [WORD_W-1:0] m;
        logic [SIZE_W+2:0] nbits;
        nbits = {nbytes, 3'b000};
        for (int i = 0; i < WORD_W; i++)
        begin
            m[i] = (i < int'(nbits));
        end
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] bit_reverse(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < WORD_W; i++)
        begin
            r[i] = w[WORD_W-1-i];
        end
        return r;
    endfunction

endpackage

### rtl/core/cbfr_front.sv
// Front end: chunk size register, input word decode and classification.
// Depends on cbfr_pkg.
module cbfr_front
    import cbfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [SIZE_W-1:0]    cfg_wdata,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output cmd_t                 cmd
);

    logic [SIZE_W-1:0] chunk_bytes_reg;
    logic [SIZE_W-1:0] chunk_bytes_next;
    logic [WORD_W-1:0] in_data;
    logic [CNT_W-1:0]  in_count;

    always_comb
    begin
        priority if (cfg_wdata == '0)
            chunk_bytes_next = SIZE_W'(1);
        else if (cfg_wdata > SIZE_W'(MAX_CHUNK_BYTES))
            chunk_bytes_next = SIZE_W'(MAX_CHUNK_BYTES);
        else
            chunk_bytes_next = cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chunk_bytes_reg <= SIZE_W'(1);
        else if (cfg_we)
            chunk_bytes_reg <= chunk_bytes_next;
    end

    assign in_data  = s_tdata[WORD_W-1:0];
    assign in_count = s_tdata[WORD_W+CNT_W-1:WORD_W];

    always_comb
    begin
        cmd.word      = in_data & byte_mask(chunk_bytes_reg);
        cmd.bytes     = chunk_bytes_reg;
        cmd.count     = in_count;
        cmd.low_end   = s_tdata[WORD_W+CNT_W];
        cmd.first_low = s_tdata[WORD_W+CNT_W+1];
        priority if (s_tuser[0] == OP_LOAD)
            cmd.kind = KIND_LOAD;
        else if (in_count > CNT_W'(MAX_FIELD_BITS))
            cmd.kind = KIND_BAD;
        else if (in_count == '0)
            cmd.kind = KIND_EMPTY;
        else
            cmd.kind = KIND_READ;
    end

endmodule

### rtl/core/cbfr_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on cbfr_pkg for the command type and depth.
module cbfr_cmd_fifo
    import cbfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic avail,
    output cmd_t head_cmd
);

    cmd_t                 entries [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign avail    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && avail;
    assign head_cmd = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (CMD_PTR_W+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (CMD_PTR_W+1)'(1);
        end
    end

endmodule

### rtl/core/cbfr_back.sv
// Back end: chunk queue memory, current chunk, segment extractor and result register.
// Depends on cbfr_pkg.
module cbfr_back
    import cbfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int QBITS_W = $clog2(QUEUE_DEPTH * WORD_W + 1);
    localparam int HELD_W  = QBITS_W + 1;
    localparam int ENTRY_W = WORD_W + SIZE_W;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + PTR_W'(1);
    endfunction

    logic [ENTRY_W-1:0] chunk_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_q;
    logic               mem_we;
    logic               rd_en;

    back_state_t        state_reg,     state_next;
    logic [FILL_W-1:0]  fill_reg,      fill_next;
    logic [PTR_W-1:0]   head_reg,      head_next;
    logic [PTR_W-1:0]   tail_reg,      tail_next;
    logic [QBITS_W-1:0] qbits_reg,     qbits_next;
    logic [WORD_W-1:0]  cur_word_reg,  cur_word_next;
    logic [SIZE_W-1:0]  cur_bytes_reg, cur_bytes_next;
    logic [CNT_W-1:0]   bits_left_reg, bits_left_next;
    logic               seg_valid_reg, seg_valid_next;
    logic               out_valid_reg, out_valid_next;

    logic [WORD_W-1:0]  seg_reg,       seg_next;
    logic [CNT_W-1:0]   seg_n_reg,     seg_n_next;
    logic [WORD_W-1:0]  acc_reg,       acc_next;
    logic [CNT_W-1:0]   remain_reg,    remain_next;
    logic [CNT_W-1:0]   total_reg,     total_next;
    logic               low_end_reg,   low_end_next;
    logic               first_low_reg, first_low_next;
    logic [WORD_W-1:0]  out_value_reg, out_value_next;
    status_t            out_status_reg, out_status_next;

    logic [HELD_W-1:0]  held;
    logic [CNT_W-1:0]   take_n;
    logic [CNT_W-1:0]   cur_width;
    logic [WORD_W-1:0]  seg_top;
    logic [WORD_W-1:0]  seg_low;
    logic [WORD_W-1:0]  rd_word;
    logic [SIZE_W-1:0]  rd_bytes;

    assign held      = HELD_W'(qbits_reg) + HELD_W'(bits_left_reg);
    assign take_n    = (remain_reg < bits_left_reg) ? remain_reg : bits_left_reg;
    assign cur_width = {cur_bytes_reg, 3'b000};
    assign seg_top   = cur_word_reg >> (cur_width - take_n);
    assign seg_low   = bit_reverse(cur_word_reg) >> (CNT_W'(WORD_W) - take_n);
    assign rd_word   = rd_q[WORD_W-1:0];
    assign rd_bytes  = rd_q[ENTRY_W-1:WORD_W];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            chunk_mem[tail_reg] <= {cmd.bytes, cmd.word};
        if (rd_en)
            rd_q <= chunk_mem[head_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        qbits_next      = qbits_reg;
        cur_word_next   = cur_word_reg;
        cur_bytes_next  = cur_bytes_reg;
        bits_left_next  = bits_left_reg;
        seg_valid_next  = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        seg_next        = seg_reg;
        seg_n_next      = seg_n_reg;
        acc_next        = acc_reg;
        remain_next     = remain_reg;
        total_next      = total_reg;
        low_end_next    = low_end_reg;
        first_low_next  = first_low_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;

        if (seg_valid_reg)
            acc_next = (acc_reg << seg_n_reg) | seg_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_pop         = 1'b1;
                    out_value_next  = '0;
                    out_status_next = STAT_OK;
                    low_end_next    = cmd.low_end;
                    first_low_next  = cmd.first_low;
                    remain_next     = cmd.count;
                    total_next      = cmd.count;
                    acc_next        = '0;
                    unique case (cmd.kind)
                        KIND_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            if (fill_reg == FILL_W'(QUEUE_DEPTH))
                                out_status_next = STAT_QUEUE_FULL;
                            else
                            begin
                                mem_we     = 1'b1;
                                tail_next  = ptr_inc(tail_reg);
                                fill_next  = fill_reg + FILL_W'(1);
                                qbits_next = qbits_reg + QBITS_W'({cmd.bytes, 3'b000});
                            end
                        end
                        KIND_BAD:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_BAD_COUNT;
                        end
                        KIND_EMPTY:
                        begin
                            out_valid_next = 1'b1;
                        end
                        KIND_READ:
                        begin
                            if (held < HELD_W'(cmd.count))
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STAT_NO_DATA;
                                bits_left_next  = '0;
                                cur_word_next   = '0;
                                head_next       = tail_reg;
                                fill_next       = '0;
                                qbits_next      = '0;
                            end
                            else
                                state_next = BK_RUN;
                        end
                    endcase
                end
            end
            BK_RUN:
            begin
                if (bits_left_reg == '0)
                begin
                    rd_en      = 1'b1;
                    head_next  = ptr_inc(head_reg);
                    fill_next  = fill_reg - FILL_W'(1);
                    state_next = BK_LOAD;
                end
                else
                begin
                    seg_valid_next = 1'b1;
                    seg_n_next     = take_n;
                    seg_next       = low_end_reg ? seg_low : seg_top;
                    cur_word_next  = low_end_reg ? (cur_word_reg >> take_n)
                                     : ((cur_word_reg << take_n) & byte_mask(cur_bytes_reg));
                    bits_left_next = bits_left_reg - take_n;
                    remain_next    = remain_reg - take_n;
                    if (remain_reg == take_n)
                        state_next = BK_DRAIN;
                end
            end
            BK_LOAD:
            begin
                cur_word_next  = rd_word;
                cur_bytes_next = rd_bytes;
                bits_left_next = {rd_bytes, 3'b000};
                qbits_next     = qbits_reg - QBITS_W'({rd_bytes, 3'b000});
                state_next     = BK_RUN;
            end
            BK_DRAIN:
            begin
                state_next = BK_FIX;
            end
            BK_FIX:
            begin
                out_valid_next  = 1'b1;
                out_status_next = STAT_OK;
                out_value_next  = first_low_reg
                                  ? (bit_reverse(acc_reg) >> (CNT_W'(WORD_W) - total_reg))
                                  : acc_reg;
                state_next      = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            fill_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            qbits_reg     <= '0;
            cur_word_reg  <= '0;
            cur_bytes_reg <= SIZE_W'(1);
            bits_left_reg <= '0;
            seg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            qbits_reg     <= qbits_next;
            cur_word_reg  <= cur_word_next;
            cur_bytes_reg <= cur_bytes_next;
            bits_left_reg <= bits_left_next;
            seg_valid_reg <= seg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg        <= seg_next;
        seg_n_reg      <= seg_n_next;
        acc_reg        <= acc_next;
        remain_reg     <= remain_next;
        total_reg      <= total_next;
        low_end_reg    <= low_end_next;
        first_low_reg  <= first_low_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

endmodule

### rtl/core/chunked_bit_field_reader_core.sv
// Top level of the chunked bit field reader: front end, command queue, back end.
// Depends on cbfr_pkg, cbfr_front, cbfr_cmd_fifo and cbfr_back.
//
// Each input word either loads a chunk of 1 to 4 bytes into a QUEUE_DEPTH-entry chunk
// memory or reads a field of up to 32 bits; every word gives exactly one result word.
// A two-entry command queue keeps taking input words until full, while the back end
// works or a result waits on m_tready. In the back end a load, a bad count or a zero
// count is answered from the idle state. A read steps through BK_RUN, BK_LOAD for each
// chunk fetched, BK_DRAIN and BK_FIX: the segment shifter handles one chunk per cycle
// while no fetch is pending, and each fetch waits on the registered read port of the
// chunk memory. The chunk memory needs no clearing after reset; a fill count guards it.
module chunked_bit_field_reader_core
    import cbfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [SIZE_W-1:0]    cfg_wdata,     // chunk_bytes
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // chunk_data, bit_count, take_low_end, first_bit_lowest
    input  logic [S_TUSER_W-1:0] s_tuser,       // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,       // field_value
    output logic [M_TUSER_W-1:0] m_tuser        // status
);

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic fifo_full;
    logic cmd_valid;
    logic cmd_pop;

    cbfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (front_cmd)
    );

    cbfr_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s_tvalid),
        .push_cmd (front_cmd),
        .full     (fifo_full),
        .pop      (cmd_pop),
        .avail    (cmd_valid),
        .head_cmd (head_cmd)
    );

    cbfr_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    assign s_tready = !fifo_full;

    a_pop_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !m_tvalid)
        else $error("command taken while a result is still pending");

    a_short_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && (head_cmd.kind != KIND_READ) |=> m_tvalid)
        else $error("load or rejected read gave no result in the next cycle");

    a_full_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> cmd_valid)
        else $error("input stalled with an empty command queue");

endmodule
